// File: rtl/okv_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// okv_pkg: shared types and constants of the keyring stream validator
// Payload structs, classified byte entries, stop reason codes, limits.
// ============================================================================
package okv_pkg;

    // Reset value of the region size register
    localparam logic [31:0] MAX_REGION_RST = 32'd16777216;
    // Packet count that ends a scan
    localparam logic [19:0] PACKET_LIMIT   = 20'd1000000;
    // Default depth of the front and result queues
    localparam int          QUEUE_DEPTH_DEF = 4;

    // OpenPGP packet tags that the order check knows
    localparam logic [5:0] TAG_SIG     = 6'd2;
    localparam logic [5:0] TAG_PUBKEY  = 6'd6;
    localparam logic [5:0] TAG_SECKEY  = 6'd7;
    localparam logic [5:0] TAG_USERID  = 6'd13;
    localparam logic [5:0] TAG_PUBSUB  = 6'd14;
    localparam logic [5:0] TAG_SECSUB  = 6'd17;

    // Stop reasons
    localparam logic [2:0] RSN_BAD_HDR  = 3'd0;
    localparam logic [2:0] RSN_ORDER    = 3'd1;
    localparam logic [2:0] RSN_INDET    = 3'd2;
    localparam logic [2:0] RSN_TRUNC    = 3'd3;
    localparam logic [2:0] RSN_OVERRUN  = 3'd4;
    localparam logic [2:0] RSN_FULL     = 3'd5;
    localparam logic [2:0] RSN_LIMIT    = 3'd6;
    localparam logic [2:0] RSN_PARTIAL  = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_region;
        logic       end_of_source;
    } t_okv_in;

    typedef struct packed {
        logic        found;
        logic [31:0] carved_length;
        logic [19:0] packet_total;
        logic [2:0]  stop_reason;
    } t_okv_out;

    // Kind of packet tag, as the order check sees it
    typedef enum logic [2:0] {
        TK_FREE,    // signature or user id
        TK_PUB,
        TK_SEC,
        TK_PSUB,
        TK_SSUB,
        TK_OTHER
    } t_okv_tag;

    // Class of a first new-format length octet
    typedef enum logic [1:0] {
        NL_ONE,     // one-octet length
        NL_TWO,     // two-octet length
        NL_FIVE,    // 0xFF followed by four octets
        NL_PART     // partial body length
    } t_okv_nlen;

    // Byte entry as classified by the front end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_region;
        logic       end_of_source;
        logic       bad_hdr;
        logic       new_fmt;
        t_okv_tag   tag_kind;
        logic       old_indet;
        logic [2:0] old_len_bytes;
        t_okv_nlen  nlen;
    } t_okv_item;

endpackage

// File: rtl/okv_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// okv_fifo: small register queue
// First-word-fall-through queue with count-based full and empty.
// ============================================================================
module okv_fifo #(
    parameter int  DEPTH = okv_pkg::QUEUE_DEPTH_DEF,
    parameter type T     = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  T     i_wdata,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output T     o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;
    logic [CW-1:0]   n_cnt;
    logic            wr_ok;
    logic            rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: rtl/okv_front.sv
`timescale 1ns / 1ps
// ============================================================================
// okv_front: byte intake and classification
// Decode header fields of each incoming byte and queue the classified entry.
// ============================================================================
module okv_front #(
    parameter int DEPTH = okv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  okv_pkg::t_okv_in   i_data,
    output logic               o_full,
    input  logic               i_take,
    output logic               o_valid,
    output okv_pkg::t_okv_item o_item
);

    okv_pkg::t_okv_item cls;
    logic [7:0]         b;
    logic [5:0]         tag;
    logic               empty;

    assign b = i_data.data_byte;

    always_comb begin
        tag = b[6] ? b[5:0] : {2'b00, b[5:2]};

        cls.data_byte       = b;
        cls.start_of_region = i_data.start_of_region;
        cls.end_of_source   = i_data.end_of_source;
        cls.bad_hdr         = !b[7] || (b == 8'hFF);
        cls.new_fmt         = b[6];
        cls.old_indet       = (b[1:0] == 2'b11);

        case (tag)
            okv_pkg::TAG_SIG:    cls.tag_kind = okv_pkg::TK_FREE;
            okv_pkg::TAG_USERID: cls.tag_kind = okv_pkg::TK_FREE;
            okv_pkg::TAG_PUBKEY: cls.tag_kind = okv_pkg::TK_PUB;
            okv_pkg::TAG_SECKEY: cls.tag_kind = okv_pkg::TK_SEC;
            okv_pkg::TAG_PUBSUB: cls.tag_kind = okv_pkg::TK_PSUB;
            okv_pkg::TAG_SECSUB: cls.tag_kind = okv_pkg::TK_SSUB;
            default:             cls.tag_kind = okv_pkg::TK_OTHER;
        endcase

        case (b[1:0])
            2'b00:   cls.old_len_bytes = 3'd1;
            2'b01:   cls.old_len_bytes = 3'd2;
            default: cls.old_len_bytes = 3'd4;
        endcase

        if (b < 8'd192) begin
            cls.nlen = okv_pkg::NL_ONE;
        end else if (b <= 8'd223) begin
            cls.nlen = okv_pkg::NL_TWO;
        end else if (b == 8'hFF) begin
            cls.nlen = okv_pkg::NL_FIVE;
        end else begin
            cls.nlen = okv_pkg::NL_PART;
        end
    end

    okv_fifo #(
        .DEPTH (DEPTH),
        .T     (okv_pkg::t_okv_item)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (cls),
        .o_full  (o_full),
        .i_rd    (i_take),
        .o_empty (empty),
        .o_rdata (o_item)
    );

    assign o_valid = !empty;

endmodule

// File: rtl/okv_scan.sv
`timescale 1ns / 1ps
// ============================================================================
// okv_scan: packet header walker
// Track header, length and payload phases, check key order, emit the result.
// ============================================================================
module okv_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_max_region,
    input  logic               i_valid,
    input  okv_pkg::t_okv_item i_item,
    output logic               o_take,
    input  logic               i_res_full,
    output logic               o_res_push,
    output okv_pkg::t_okv_out  o_res
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_TAG      = 6'b000010,
        ST_NEWLEN1  = 6'b000100,
        ST_NEW2     = 6'b001000,
        ST_LENBYTES = 6'b010000,
        ST_PAYLOAD  = 6'b100000
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [32:0] r_pos,    n_pos;
    logic [31:0] r_last,   n_last;
    logic [2:0]  r_hbl,    n_hbl;
    logic [31:0] r_lacc,   n_lacc;
    logic [31:0] r_pl,     n_pl;
    logic [19:0] r_cnt,    n_cnt;
    logic        r_pub,    n_pub;
    logic        r_sec,    n_sec;

    always_comb begin
        t_phase      ph;
        logic        start;
        logic        eos;
        logic [32:0] pos;
        logic [19:0] cnt;
        logic        pub;
        logic        sec;
        logic        ok;
        logic        do_acc;
        logic [31:0] len;
        logic [33:0] pend;
        logic [19:0] cnt_inc;
        logic [31:0] lacc_sh;
        logic [2:0]  hbl_dec;
        logic        fin;
        logic [2:0]  rsn;

        start   = i_item.start_of_region;
        eos     = i_item.end_of_source;
        o_take  = i_valid && !i_res_full;

        // a region start drops any running scan
        ph      = start ? ST_TAG : r_phase;
        pos     = start ? '0 : r_pos;
        cnt     = start ? '0 : r_cnt;
        pub     = start ? 1'b0 : r_pub;
        sec     = start ? 1'b0 : r_sec;

        ok      = 1'b0;
        do_acc  = 1'b0;
        len     = '0;
        pend    = '0;
        fin     = 1'b0;
        rsn     = okv_pkg::RSN_BAD_HDR;
        cnt_inc = cnt + 20'd1;
        lacc_sh = {r_lacc[23:0], i_item.data_byte};
        hbl_dec = (r_hbl != 3'd0) ? r_hbl - 3'd1 : 3'd0;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_last  = r_last;
        n_hbl   = r_hbl;
        n_lacc  = r_lacc;
        n_pl    = r_pl;
        n_cnt   = r_cnt;
        n_pub   = r_pub;
        n_sec   = r_sec;

        if (o_take) begin
            n_phase = ph;
            n_pos   = pos + 33'd1;
            n_last  = start ? '0 : r_last;
            n_hbl   = start ? '0 : r_hbl;
            n_lacc  = start ? '0 : r_lacc;
            n_pl    = start ? '0 : r_pl;
            n_cnt   = cnt;
            n_pub   = pub;
            n_sec   = sec;

            if (start && (i_max_region == '0)) begin
                fin = 1'b1;
                rsn = okv_pkg::RSN_FULL;
            end else begin
                case (ph)
                    ST_TAG: begin
                        if (i_item.bad_hdr) begin
                            fin = 1'b1;
                            rsn = okv_pkg::RSN_BAD_HDR;
                        end else begin
                            if (cnt == '0) begin
                                ok    = (i_item.tag_kind == okv_pkg::TK_PUB) ||
                                        (i_item.tag_kind == okv_pkg::TK_SEC);
                                n_pub = (i_item.tag_kind == okv_pkg::TK_PUB);
                                n_sec = (i_item.tag_kind == okv_pkg::TK_SEC);
                            end else begin
                                case (i_item.tag_kind)
                                    okv_pkg::TK_FREE: ok = 1'b1;
                                    okv_pkg::TK_PUB: begin
                                        ok    = !sec;
                                        n_pub = 1'b1;
                                    end
                                    okv_pkg::TK_SEC: begin
                                        ok    = !pub;
                                        n_sec = 1'b1;
                                    end
                                    okv_pkg::TK_PSUB: ok = pub && !sec;
                                    okv_pkg::TK_SSUB: ok = sec && !pub;
                                    default:          ok = 1'b0;
                                endcase
                            end
                            n_lacc = '0;
                            if (!ok) begin
                                fin = 1'b1;
                                rsn = okv_pkg::RSN_ORDER;
                            end else if (!i_item.new_fmt && i_item.old_indet) begin
                                fin = 1'b1;
                                rsn = okv_pkg::RSN_INDET;
                            end else begin
                                n_hbl   = i_item.new_fmt ? 3'd1 : i_item.old_len_bytes;
                                n_phase = i_item.new_fmt ? ST_NEWLEN1 : ST_LENBYTES;
                                if (eos) begin
                                    fin = 1'b1;
                                    rsn = okv_pkg::RSN_TRUNC;
                                end
                            end
                        end
                    end
                    ST_NEWLEN1: begin
                        case (i_item.nlen)
                            okv_pkg::NL_ONE: begin
                                do_acc = 1'b1;
                                len    = {24'd0, i_item.data_byte};
                            end
                            okv_pkg::NL_TWO: begin
                                // first octet minus 192 is its low five bits
                                n_lacc  = {27'd0, i_item.data_byte[4:0]};
                                n_hbl   = 3'd1;
                                n_phase = ST_NEW2;
                                if (eos) begin
                                    fin = 1'b1;
                                    rsn = okv_pkg::RSN_TRUNC;
                                end
                            end
                            okv_pkg::NL_FIVE: begin
                                n_lacc  = '0;
                                n_hbl   = 3'd4;
                                n_phase = ST_LENBYTES;
                                if (eos) begin
                                    fin = 1'b1;
                                    rsn = okv_pkg::RSN_TRUNC;
                                end
                            end
                            default: begin
                                fin = 1'b1;
                                rsn = okv_pkg::RSN_PARTIAL;
                            end
                        endcase
                    end
                    ST_NEW2: begin
                        do_acc = 1'b1;
                        len    = {19'd0, r_lacc[4:0], i_item.data_byte} + 32'd192;
                    end
                    ST_LENBYTES: begin
                        n_lacc = lacc_sh;
                        n_hbl  = hbl_dec;
                        if (hbl_dec == 3'd0) begin
                            do_acc = 1'b1;
                            len    = lacc_sh;
                        end else if (eos) begin
                            fin = 1'b1;
                            rsn = okv_pkg::RSN_TRUNC;
                        end
                    end
                    ST_PAYLOAD: begin
                        n_pl = (r_pl != '0) ? r_pl - 32'd1 : '0;
                        if (n_pl == '0) begin
                            n_phase = ST_TAG;
                        end
                        if (eos) begin
                            fin = 1'b1;
                            rsn = okv_pkg::RSN_TRUNC;
                        end
                    end
                    default: begin
                        // outside a region: drop the byte
                        n_pos = r_pos;
                    end
                endcase
            end

            if (do_acc) begin
                pend = {1'b0, pos} + 34'd1 + {2'b00, len};
                if (pend > {2'b00, i_max_region}) begin
                    fin = 1'b1;
                    rsn = okv_pkg::RSN_OVERRUN;
                end else begin
                    n_last = pend[31:0];
                    n_cnt  = cnt_inc;
                    if (pend[31:0] == i_max_region) begin
                        fin = 1'b1;
                        rsn = okv_pkg::RSN_FULL;
                    end else if (cnt_inc >= okv_pkg::PACKET_LIMIT) begin
                        fin = 1'b1;
                        rsn = okv_pkg::RSN_LIMIT;
                    end else if (eos) begin
                        fin = 1'b1;
                        rsn = okv_pkg::RSN_TRUNC;
                    end else begin
                        n_pl    = len;
                        n_hbl   = 3'd0;
                        n_phase = (len != '0) ? ST_PAYLOAD : ST_TAG;
                    end
                end
            end

            if (fin) begin
                n_phase = ST_IDLE;
            end
        end

        o_res_push          = o_take && fin;
        o_res.found         = (n_cnt != '0);
        o_res.carved_length = (n_cnt != '0) ? n_last : '0;
        o_res.packet_total  = n_cnt;
        o_res.stop_reason   = rsn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_IDLE;
            r_pos   <= '0;
            r_last  <= '0;
            r_hbl   <= '0;
            r_lacc  <= '0;
            r_pl    <= '0;
            r_cnt   <= '0;
            r_pub   <= 1'b0;
            r_sec   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_last  <= n_last;
            r_hbl   <= n_hbl;
            r_lacc  <= n_lacc;
            r_pl    <= n_pl;
            r_cnt   <= n_cnt;
            r_pub   <= n_pub;
            r_sec   <= n_sec;
        end
    end

endmodule

// File: rtl/openpgp_keyring_stream_validator.sv
`timescale 1ns / 1ps
// ============================================================================
// openpgp_keyring_stream_validator: OpenPGP keyring stream validator
// Walk packet headers of a byte stream, check keyring order and report the
// carved length of the region once the walk stops.
// ============================================================================
//
// Channel  | Handshake                 | Payload             | Transfer when
// ---------+---------------------------+---------------------+------------------
// input    | push (in), full (out)     | i_data (t_okv_in)   | push && !full
// result   | empty (out), pop (in)     | o_result (t_okv_out)| pop && !empty
// config   | i_cfg_valid, o_cfg_ready  | i_cfg_data (32 b)   | valid && ready
//
// Cycles: one byte per clock sustained while the result queue has room; a byte
// transfers into the front queue, the walker consumes one queued byte per clock
// and writes at most one result. Empty falls once the walker has taken the
// stopping byte from the front queue and pushed its result into the result queue.
// Stalls: a full result queue holds the walker; the front queue keeps taking
// bytes until it too fills, then full rises.
// Reset: synchronous, active low; clears both queues and the walker, and loads
// the region size register with its default. No clearing pass is needed.
// ============================================================================
module openpgp_keyring_stream_validator #(
    parameter int QUEUE_DEPTH = okv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              push,
    input  okv_pkg::t_okv_in  i_data,
    output logic              full,
    // results
    output logic              empty,
    input  logic              pop,
    output okv_pkg::t_okv_out o_result,
    // region size register
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data
);

    logic [31:0]        r_max_region;
    logic               item_valid;
    okv_pkg::t_okv_item item;
    logic               item_take;
    logic               res_full;
    logic               res_push;
    okv_pkg::t_okv_out  res;

    // Register writes must arrive only while the block is idle; the block does not enforce it and is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_region <= okv_pkg::MAX_REGION_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_region <= i_cfg_data;
        end
    end

    // Front: classify each byte and queue it.
    okv_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_data),
        .o_full  (full),
        .i_take  (item_take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // Back: walk headers and payloads, advance only when a result slot is free.
    okv_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_region (r_max_region),
        .i_valid      (item_valid),
        .i_item       (item),
        .o_take       (item_take),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res)
    );

    // Result queue: hold finished results until the consumer pops them.
    okv_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .T     (okv_pkg::t_okv_out)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (o_result)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the OpenPGP keyring stream validator
// Streams directed and random keyring regions through the byte queue, walks
// every byte through a local packet-header walker, and checks each stop
// report that the block emits. The bench steps through region sizes and
// handshake pacing modes between phases.
// ============================================================================
module tb;

    // Cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // Cycles to let a byte still inside the block finish after the last report
    localparam int SETTLE_TICKS = 8;
    localparam int PHASE_BYTES  = 110;
    localparam int PHASE_STOPS  = 2;
    localparam int MISS_PRINTS  = 40;

    // Walker state of the local header parser
    typedef enum logic [2:0] {
        WS_IDLE,
        WS_TAG,
        WS_NLEN1,
        WS_LENB,
        WS_NLEN2,
        WS_BODY
    } t_walk;

    // One pending byte plus a flag that holds it until all reports are in
    typedef struct {
        okv_pkg::t_okv_in d;
        bit               drain;
    } t_feed;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    okv_pkg::t_okv_in  i_data;
    logic              full;
    logic              empty;
    logic              pop;
    okv_pkg::t_okv_out o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [31:0]       i_cfg_data;

    openpgp_keyring_stream_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_data      (i_data),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Stimulus and expectation stores
    t_feed             byte_q[$];
    okv_pkg::t_okv_out carve_q[$];
    okv_pkg::t_okv_in  rgn_q[$];
    t_feed             next_feed;

    // Pacing knobs, in percent of cycles
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Local copy of the region size register and walker state
    logic [31:0] rgn_limit;
    t_walk       ws;
    logic [63:0] pos;
    logic [63:0] last_end;
    logic [63:0] acc;
    logic [63:0] body_left;
    logic [2:0]  hdr_left;
    int unsigned pkts;
    bit          seen_pub;
    bit          seen_sec;

    // Bookkeeping
    bit          in_taken;
    int unsigned idle_ticks;
    int unsigned miss_cnt;
    int unsigned bytes_in;
    int unsigned reports_seen;
    int unsigned regions_built;
    int unsigned limit_settings;
    int unsigned phase_bytes;

    // ------------------------------------------------------------------------
    // Header walker: mirrors the block's byte-by-byte packet walk
    // ------------------------------------------------------------------------

    // Close the walk and queue the stop report it produces.
    function automatic void stop_walk(input logic [2:0] why);
        okv_pkg::t_okv_out r;
        r.found         = (pkts != 0);
        r.carved_length = r.found ? last_end[31:0] : 32'd0;
        r.packet_total  = pkts[19:0];
        r.stop_reason   = why;
        carve_q.insert(carve_q.size(), r);
        ws = WS_IDLE;
    endfunction

    // Header is complete on the current byte; decide whether the packet fits.
    function automatic void accept_pkt(input logic [63:0] len, input bit eos);
        logic [63:0] pkt_end;
        pkt_end = pos + 64'd1 + len;
        if (pkt_end > {32'd0, rgn_limit}) begin
            stop_walk(okv_pkg::RSN_OVERRUN);
            return;
        end
        last_end = pkt_end;
        pkts++;
        if (pkt_end >= {32'd0, rgn_limit}) begin
            stop_walk(okv_pkg::RSN_FULL);
        end else if (pkts >= {12'd0, okv_pkg::PACKET_LIMIT}) begin
            stop_walk(okv_pkg::RSN_LIMIT);
        end else if (eos) begin
            stop_walk(okv_pkg::RSN_TRUNC);
        end else begin
            body_left = len;
            hdr_left  = 3'd0;
            ws        = (len != 0) ? WS_BODY : WS_TAG;
        end
    endfunction

    // Packet tag byte: check the format bits and the keyring order.
    function automatic void walk_tag(input logic [7:0] b, input bit eos);
        logic [5:0] tag;
        bit         ok;
        if (b < 8'h80 || b == 8'hFF) begin
            stop_walk(okv_pkg::RSN_BAD_HDR);
            return;
        end
        tag = b[6] ? b[5:0] : {2'b00, b[5:2]};
        if (pkts == 0) begin
            ok = (tag == okv_pkg::TAG_PUBKEY) || (tag == okv_pkg::TAG_SECKEY);
            if (ok) begin
                seen_pub = (tag == okv_pkg::TAG_PUBKEY);
                seen_sec = (tag == okv_pkg::TAG_SECKEY);
            end
        end else begin
            case (tag)
                okv_pkg::TAG_SIG, okv_pkg::TAG_USERID: ok = 1'b1;
                okv_pkg::TAG_PUBKEY: begin
                    ok       = !seen_sec;
                    seen_pub = 1'b1;
                end
                okv_pkg::TAG_SECKEY: begin
                    ok       = !seen_pub;
                    seen_sec = 1'b1;
                end
                okv_pkg::TAG_PUBSUB: ok = seen_pub && !seen_sec;
                okv_pkg::TAG_SECSUB: ok = seen_sec && !seen_pub;
                default:             ok = 1'b0;
            endcase
        end
        if (!ok) begin
            stop_walk(okv_pkg::RSN_ORDER);
            return;
        end
        acc = 64'd0;
        if (!b[6]) begin
            if (b[1:0] == 2'd3) begin
                stop_walk(okv_pkg::RSN_INDET);
                return;
            end
            hdr_left = (b[1:0] == 2'd0) ? 3'd1 : ((b[1:0] == 2'd1) ? 3'd2 : 3'd4);
            ws       = WS_LENB;
        end else begin
            hdr_left = 3'd1;
            ws       = WS_NLEN1;
        end
        if (eos) stop_walk(okv_pkg::RSN_TRUNC);
    endfunction

    // Advance the walker by one accepted byte.
    function automatic void walk_byte(input okv_pkg::t_okv_in it);
        logic [7:0] b;
        bit         eos;
        b   = it.data_byte;
        eos = it.end_of_source;
        if (it.start_of_region) begin
            ws        = WS_IDLE;
            pos       = 64'd0;
            last_end  = 64'd0;
            acc       = 64'd0;
            body_left = 64'd0;
            hdr_left  = 3'd0;
            pkts      = 0;
            seen_pub  = 1'b0;
            seen_sec  = 1'b0;
            if (rgn_limit == 32'd0) begin
                stop_walk(okv_pkg::RSN_FULL);
                return;
            end
            walk_tag(b, eos);
            pos++;
            return;
        end
        case (ws)
            WS_TAG: walk_tag(b, eos);
            WS_NLEN1: begin
                if (b < 8'd192) begin
                    accept_pkt({56'd0, b}, eos);
                end else if (b <= 8'd223) begin
                    acc      = {56'd0, b} - 64'd192;
                    hdr_left = 3'd1;
                    ws       = WS_NLEN2;
                    if (eos) stop_walk(okv_pkg::RSN_TRUNC);
                end else if (b == 8'hFF) begin
                    acc      = 64'd0;
                    hdr_left = 3'd4;
                    ws       = WS_LENB;
                    if (eos) stop_walk(okv_pkg::RSN_TRUNC);
                end else begin
                    stop_walk(okv_pkg::RSN_PARTIAL);
                end
            end
            WS_NLEN2: accept_pkt((acc << 8) + {56'd0, b} + 64'd192, eos);
            WS_LENB: begin
                acc = ((acc << 8) | {56'd0, b}) & 64'hFFFF_FFFF;
                if (hdr_left != 0) hdr_left--;
                if (hdr_left == 0) accept_pkt(acc, eos);
                else if (eos) stop_walk(okv_pkg::RSN_TRUNC);
            end
            WS_BODY: begin
                if (body_left != 0) body_left--;
                if (body_left == 0) ws = WS_TAG;
                if (eos) stop_walk(okv_pkg::RSN_TRUNC);
            end
            default: return;
        endcase
        pos++;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    // Queue one byte for the driver.
    function automatic void put(input logic [7:0] b, input bit s, input bit e);
        t_feed f;
        f.d.data_byte       = b;
        f.d.start_of_region = s;
        f.d.end_of_source   = e;
        f.drain             = 1'b0;
        byte_q.insert(byte_q.size(), f);
        phase_bytes++;
    endfunction

    function automatic void rgn_add(input logic [7:0] b);
        okv_pkg::t_okv_in it;
        it.data_byte       = b;
        it.start_of_region = 1'b0;
        it.end_of_source   = 1'b0;
        rgn_q.insert(rgn_q.size(), it);
    endfunction

    // Mostly tiny bodies, a few that need the two-octet length form.
    function automatic logic [31:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 32'($urandom_range(0, 6));
        if (r < 95) return 32'($urandom_range(7, 40));
        return 32'($urandom_range(192, 230));
    endfunction

    // Tag for the next packet of a keyring of the given kind.
    function automatic logic [5:0] pick_tag(input bit first, input bit sec);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (first) begin
            return (r < 92) ? (sec ? okv_pkg::TAG_SECKEY : okv_pkg::TAG_PUBKEY)
                            : 6'($urandom_range(0, 63));
        end
        if (r < 30) return okv_pkg::TAG_SIG;
        if (r < 55) return okv_pkg::TAG_USERID;
        if (r < 80) return sec ? okv_pkg::TAG_SECSUB : okv_pkg::TAG_PUBSUB;
        if (r < 90) return sec ? okv_pkg::TAG_SECKEY : okv_pkg::TAG_PUBKEY;
        if (r < 95) return sec ? okv_pkg::TAG_PUBSUB : okv_pkg::TAG_SECKEY;
        return 6'($urandom_range(0, 63));
    endfunction

    // Header in a random legal encoding for len, then the body if asked.
    function automatic void build_packet(input logic [5:0] tag, input logic [31:0] len,
                                         input bit body);
        int unsigned form;
        logic [12:0] two;
        if (tag < 6'd16 && $urandom_range(0, 1) == 1) begin
            if (len < 256)        form = $urandom_range(0, 2);
            else if (len < 65536) form = $urandom_range(1, 2);
            else                  form = 2;
            rgn_add({2'b10, tag[3:0], form[1:0]});
            if (form == 2) begin
                rgn_add(len[31:24]);
                rgn_add(len[23:16]);
            end
            if (form != 0) rgn_add(len[15:8]);
            rgn_add(len[7:0]);
        end else begin
            rgn_add({2'b11, tag});
            if (len < 192 && $urandom_range(0, 3) != 0) begin
                rgn_add(len[7:0]);
            end else if (len >= 192 && len <= 8383 && $urandom_range(0, 3) != 0) begin
                two = 13'(len - 32'd192);
                rgn_add(8'd192 + {3'd0, two[12:8]});
                rgn_add(two[7:0]);
            end else begin
                rgn_add(8'hFF);
                rgn_add(len[31:24]);
                rgn_add(len[23:16]);
                rgn_add(len[15:8]);
                rgn_add(len[7:0]);
            end
        end
        if (body) begin
            for (int unsigned i = 0; i < len; i++) rgn_add(8'($urandom_range(0, 255)));
        end
    endfunction

    // Append a byte sequence that breaks the walk at a tag position.
    function automatic void add_bad_tail(input bit sec);
        case ($urandom_range(0, 4))
            0: rgn_add(8'($urandom_range(0, 127)));
            1: rgn_add(8'hFF);
            2: rgn_add({2'b11, sec ? okv_pkg::TAG_PUBKEY : okv_pkg::TAG_SECKEY});
            3: rgn_add({2'b10, okv_pkg::TAG_SIG[3:0], 2'b11});
            default: begin
                rgn_add({2'b11, okv_pkg::TAG_USERID});
                rgn_add(8'($urandom_range(224, 254)));
            end
        endcase
    endfunction

    // Build one keyring region with random content and a random ending.
    // Return 1 when the region is shaped to end in a stop report.
    function automatic int gen_region();
        int unsigned n_pkt;
        int unsigned ending;
        int unsigned cut;
        bit          sec;
        bit          huge;
        t_feed       f;
        rgn_q.delete();
        n_pkt = $urandom_range(1, 5);
        sec   = 1'($urandom_range(0, 1));
        for (int unsigned i = 0; i < n_pkt; i++) begin
            huge = ($urandom_range(0, 24) == 0);
            build_packet(pick_tag(i == 0, sec), huge ? $urandom : pick_len(), !huge);
            // a huge body never arrives; end the region right after its header
            if (huge) break;
        end
        ending = $urandom_range(0, 9);
        if (ending <= 3) begin
            // cut the source short on a random byte
            cut = $urandom_range(0, rgn_q.size() - 1);
            while (rgn_q.size() > cut + 1) void'(rgn_q.pop_back());
            rgn_q[rgn_q.size() - 1].end_of_source = 1'b1;
        end else if (ending <= 7) begin
            add_bad_tail(sec);
        end
        rgn_q[0].start_of_region = 1'b1;
        foreach (rgn_q[i]) begin
            f.d     = rgn_q[i];
            f.drain = (i == 0) && ($urandom_range(0, 15) == 0);
            byte_q.insert(byte_q.size(), f);
        end
        phase_bytes += rgn_q.size();
        regions_built++;
        // stray bytes between regions; these do not count toward the phase
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                f.d.data_byte       = 8'($urandom_range(0, 255));
                f.d.start_of_region = 1'b0;
                f.d.end_of_source   = 1'($urandom_range(0, 1));
                f.drain             = 1'b0;
                byte_q.insert(byte_q.size(), f);
            end
        end
        return (ending <= 7) ? 1 : 0;
    endfunction

    // ------------------------------------------------------------------------
    // Checking helpers and phase control
    // ------------------------------------------------------------------------

    task automatic log_miss(input string what, input logic [31:0] got, input logic [31:0] want);
        miss_cnt++;
        if (miss_cnt <= MISS_PRINTS)
            $display("MISS %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    endtask

    // Wait until every byte is in and every report is out, then let the
    // block finish any byte that produces no report.
    task automatic settle();
        while (byte_q.size() != 0 || push || carve_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
        // a last byte taken during the ticks above may still owe a report
        while (carve_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_region_limit(input logic [31:0] lim);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present bytes on the falling edge, hold each until it transfers
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!push || in_taken) begin
                // hold a drain-marked byte until every report has come back
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                        && !(byte_q[0].drain && carve_q.size() != 0)) begin
                    next_feed = byte_q.pop_front();
                    push   <= 1'b1;
                    i_data <= next_feed.d;
                end else begin
                    push <= 1'b0;
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample transfers on the rising edge, check reports, predict,
    // and track the register write; the watchdog lives here too
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_ticks++;
            // check the report first so a fresh prediction is never consumed
            if (pop && !empty) begin
                idle_ticks = 0;
                reports_seen++;
                if (carve_q.size() == 0) begin
                    log_miss("report with nothing expected", {29'd0, o_result.stop_reason}, 0);
                end else begin
                    if (o_result.found !== carve_q[0].found)
                        log_miss("found", {31'd0, o_result.found}, {31'd0, carve_q[0].found});
                    if (o_result.carved_length !== carve_q[0].carved_length)
                        log_miss("carved_length", o_result.carved_length,
                                 carve_q[0].carved_length);
                    if (o_result.packet_total !== carve_q[0].packet_total)
                        log_miss("packet_total", {12'd0, o_result.packet_total},
                                 {12'd0, carve_q[0].packet_total});
                    if (o_result.stop_reason !== carve_q[0].stop_reason)
                        log_miss("stop_reason", {29'd0, o_result.stop_reason},
                                 {29'd0, carve_q[0].stop_reason});
                    void'(carve_q.pop_front());
                end
            end
            in_taken = push && !full;
            if (in_taken) begin
                idle_ticks = 0;
                bytes_in++;
                walk_byte(i_data);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                idle_ticks = 0;
                rgn_limit  = i_cfg_data;
            end
            if (idle_ticks >= STALL_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed regions, then random phases
    // ------------------------------------------------------------------------
    initial begin
        // drive every input to a known value before the first edge
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_data         = '0;
        pop            = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 32'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rgn_limit      = okv_pkg::MAX_REGION_RST;
        ws             = WS_IDLE;
        pos            = 64'd0;
        last_end       = 64'd0;
        acc            = 64'd0;
        body_left      = 64'd0;
        hdr_left       = 3'd0;
        pkts           = 0;
        seen_pub       = 1'b0;
        seen_sec       = 1'b0;
        in_taken       = 1'b0;
        idle_ticks     = 0;
        miss_cnt       = 0;
        bytes_in       = 0;
        reports_seen   = 0;
        regions_built  = 0;
        limit_settings = 0;
        phase_bytes    = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed at the reset region size.
        // Public key, user id, then a signature with a two-octet length whose body is
        // cut short by the end of the source right after its header.
        put(8'h98, 1, 0); put(8'h00, 0, 0);
        put(8'hCD, 0, 0); put(8'h01, 0, 0); put(8'hAA, 0, 0);
        put(8'hC2, 0, 0); put(8'hC0, 0, 0); put(8'h00, 0, 1);
        // ignored: the walk has already stopped
        put(8'h55, 0, 0);
        // started scan that the next region start drops without a report
        put(8'hC6, 1, 0); put(8'h05, 0, 0); put(8'h01, 0, 0);
        // secret key with five-octet zero length, then a public subkey
        put(8'hC7, 1, 0); put(8'hFF, 0, 0);
        put(8'h00, 0, 0); put(8'h00, 0, 0); put(8'h00, 0, 0); put(8'h00, 0, 0);
        put(8'hB8, 0, 0);
        // header error on the last source byte wins over truncation
        put(8'h7F, 1, 1);
        put(8'hFF, 1, 0);
        // old format with indeterminate length
        put(8'h9B, 1, 0);
        // partial body length
        put(8'hC6, 1, 0); put(8'hE0, 0, 0);
        // source ends inside the first header
        put(8'hC6, 1, 1);
        settle();

        // Largest region: fill it exactly, overrun it, longest two-octet form, partial length.
        set_region_limit(32'hFFFF_FFFF);
        @(posedge i_clk);
        put(8'h9A, 1, 0); put(8'hFF, 0, 0); put(8'hFF, 0, 0); put(8'hFF, 0, 0);
        put(8'hFA, 0, 0);
        put(8'hC6, 1, 0); put(8'hFF, 0, 0); put(8'hFF, 0, 0); put(8'hFF, 0, 0);
        put(8'hFF, 0, 0); put(8'hFB, 0, 0);
        put(8'hC6, 1, 0); put(8'hDF, 0, 0); put(8'hFF, 0, 0); put(8'h80, 0, 1);
        put(8'hC7, 1, 0); put(8'hFE, 0, 0);
        settle();

        // One-byte region: the first packet can never fit.
        set_region_limit(32'd1);
        @(posedge i_clk);
        put(8'h98, 1, 0); put(8'h00, 0, 0);
        settle();

        // Random phases, cycling through the pacing modes.
        for (int p = 0; p < 8; p++) begin
            int unsigned stops;
            logic [31:0] lim;
            case (p)
                0:       lim = 32'd48;
                1:       lim = 32'd2;
                2:       lim = 32'hFFFF_FFFF;
                3:       lim = 32'd200;
                4:       lim = okv_pkg::MAX_REGION_RST;
                5:       lim = 32'($urandom_range(20, 600));
                6:       lim = 32'd96;
                default: lim = 32'($urandom_range(1, 32'hFFFF_FFFF));
            endcase
            set_region_limit(lim);
            @(posedge i_clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            phase_bytes = 0;
            stops       = 0;
            while (phase_bytes < PHASE_BYTES || stops < PHASE_STOPS) stops += gen_region();
            // close any open walk so the next register write finds the block idle
            put(8'($urandom_range(0, 127)), 1, 0);
            settle();
        end

        if (carve_q.size() != 0) log_miss("reports never delivered", carve_q.size(), 0);
        $display("Streamed %0d bytes (%0d random regions), checked %0d stop reports",
                 bytes_in, regions_built, reports_seen);
        $display("across %0d region size writes and four pacing modes", limit_settings);
        if (miss_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/okv_pkg.sv
rtl/okv_fifo.sv
rtl/okv_front.sv
rtl/okv_scan.sv
rtl/openpgp_keyring_stream_validator.sv
test/tb.sv
